// ----- hdl/mpwc_pkg.sv -----
package mpwc_pkg;

   localparam int CHANNEL_W = 4;
   localparam int TIME_W    = 32;
   localparam int LIMIT_W   = 16;
   localparam int TIMEOUT_W = 24;
   localparam int MASK_W    = 16;
   localparam int CSR_IDX_W = 8;
   localparam int CSR_DATA_W = 32;

   localparam logic [CSR_IDX_W-1:0] CSR_ENABLE_MASK = 8'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_WIDTH   = 8'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_WIDTH   = 8'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_TIMEOUT     = 8'd3;

   localparam logic [MASK_W-1:0]    RESET_ENABLE_MASK = 16'd0;
   localparam logic [LIMIT_W-1:0]   RESET_MIN_WIDTH   = 16'd500;
   localparam logic [LIMIT_W-1:0]   RESET_MAX_WIDTH   = 16'd2500;
   localparam logic [TIMEOUT_W-1:0] RESET_TIMEOUT     = 24'd200000;

   typedef struct packed {
      logic              level;
      logic [TIME_W-1:0] rise_time;
      logic [TIME_W-1:0] width;
   } chan_entry_type;

   localparam int ENTRY_W = $bits(chan_entry_type);

   typedef struct packed {
      logic [CHANNEL_W-1:0] result_channel;
      logic [TIME_W-1:0]    width_us;
      logic                 width_done;
      logic                 width_valid;
      logic                 signal_present;
   } rsp_item_type;

endpackage

// ----- hdl/mpwc_ifs.sv -----
interface mpwc_req_if
   import mpwc_pkg::*;
();
   logic                 valid;
   logic                 ready;
   logic [CHANNEL_W-1:0] channel;
   logic                 pin_level;
   logic [TIME_W-1:0]    time_us;

   modport source (output valid, output channel, output pin_level, output time_us,
                   input ready);
   modport sink   (input valid, input channel, input pin_level, input time_us,
                   output ready);
endinterface

interface mpwc_rsp_if
   import mpwc_pkg::*;
();
   logic                 valid;
   logic                 ready;
   logic [CHANNEL_W-1:0] result_channel;
   logic [TIME_W-1:0]    width_us;
   logic                 width_done;
   logic                 width_valid;
   logic                 signal_present;

   modport source (output valid, output result_channel, output width_us,
                   output width_done, output width_valid, output signal_present,
                   input ready);
   modport sink   (input valid, input result_channel, input width_us,
                   input width_done, input width_valid, input signal_present,
                   output ready);
endinterface

interface mpwc_csr_if
   import mpwc_pkg::*;
();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- hdl/multichannel_pulse_width_capture.sv -----
// Pulse-width capture for up to NUM_CHANNELS pins sharing one sample stream. One pin sample
// is taken per clock while the input is ready; its result is formed in stage one and pushed
// into the result queue. The per-channel state (last level, rise time, last width) sits in
// a single-port-write RAM read as the sample is accepted, with the previous write forwarded
// when consecutive samples hit the same channel. After reset all channels read as zero
// without any clearing pass. A three-entry result queue keeps samples flowing while results
// wait; the input stalls only when that queue, counting the sample still in flight, is full.
// Configuration registers: 0 enable mask, 1 minimum width, 2 maximum width, 3 timeout
// (widths and timeout in microseconds); the configuration port is always ready.
module multichannel_pulse_width_capture
   import mpwc_pkg::*;
#(
   parameter int NUM_CHANNELS = 16
) (
   input  logic       clock,
   input  logic       reset,
   mpwc_req_if.sink   req_chan,
   mpwc_rsp_if.source rsp_chan,
   mpwc_csr_if.sink   csr_chan
);

   localparam int AW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
   localparam logic [5:0] NCH = 6'(NUM_CHANNELS);
   localparam int QUEUE_DEPTH = 3;
   localparam logic [1:0] QUEUE_LAST = 2'(QUEUE_DEPTH - 1);
   localparam logic [2:0] QUEUE_FULL = 3'(QUEUE_DEPTH);

   // configuration
   logic [MASK_W-1:0]    mask_ff;
   logic [LIMIT_W-1:0]   min_ff;
   logic [LIMIT_W-1:0]   max_ff;
   logic [TIMEOUT_W-1:0] timeout_ff;

   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff    <= RESET_ENABLE_MASK;
         min_ff     <= RESET_MIN_WIDTH;
         max_ff     <= RESET_MAX_WIDTH;
         timeout_ff <= RESET_TIMEOUT;
      end else if (csr_chan.valid) begin
         case (csr_chan.index)
            CSR_ENABLE_MASK: mask_ff    <= csr_chan.data[MASK_W-1:0];
            CSR_MIN_WIDTH:   min_ff     <= csr_chan.data[LIMIT_W-1:0];
            CSR_MAX_WIDTH:   max_ff     <= csr_chan.data[LIMIT_W-1:0];
            CSR_TIMEOUT:     timeout_ff <= csr_chan.data[TIMEOUT_W-1:0];
            default: ;
         endcase
      end
   end

   // input transaction and stage one
   logic                 req_accept;
   logic                 s1_valid_ff;
   logic [CHANNEL_W-1:0] s1_ch_ff;
   logic                 s1_level_ff;
   logic [TIME_W-1:0]    s1_time_ff;
   logic [5:0]           req_ch6;
   logic [AW-1:0]        rd_addr;

   assign req_accept = req_chan.valid && req_chan.ready;
   assign req_ch6    = {2'b00, req_chan.channel};
   assign rd_addr    = req_ch6[AW-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= req_accept;
      end
      if (req_accept) begin
         s1_ch_ff    <= req_chan.channel;
         s1_level_ff <= req_chan.pin_level;
         s1_time_ff  <= req_chan.time_us;
      end
   end

   // channel state memory
   logic                    wr_en;
   logic [AW-1:0]           s1_addr;
   logic [ENTRY_W-1:0]      ram_rd_data;
   chan_entry_type          new_entry;
   logic [NUM_CHANNELS-1:0] written_ff;
   logic                    fwd_valid_ff;
   logic [AW-1:0]           fwd_addr_ff;
   chan_entry_type          fwd_entry_ff;

   mpwc_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (NUM_CHANNELS)
   ) u_state_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (s1_addr),
      .wr_data (new_entry),
      .rd_addr (rd_addr),
      .rd_data (ram_rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         written_ff   <= '0;
         fwd_valid_ff <= 1'b0;
      end else begin
         fwd_valid_ff <= wr_en;
         if (wr_en) begin
            written_ff[s1_addr] <= 1'b1;
         end
      end
      fwd_addr_ff  <= s1_addr;
      fwd_entry_ff <= new_entry;
   end

   // read-modify-write
   logic [5:0]        s1_ch6;
   logic              in_range;
   logic              enabled;
   chan_entry_type    old_entry;
   logic [TIME_W-1:0] diff;
   logic              edge_seen;
   logic              done;
   logic              valid;
   logic              valid_seen_ff;
   logic              valid_seen_in;
   logic [TIME_W-1:0] last_valid_ff;
   logic [TIME_W-1:0] last_valid_in;
   logic [TIME_W-1:0] gap;
   logic              present;
   rsp_item_type      s1_item;

   always_comb begin
      s1_ch6   = {2'b00, s1_ch_ff};
      in_range = s1_ch6 < NCH;
      s1_addr  = s1_ch6[AW-1:0];
      enabled  = in_range && mask_ff[s1_ch_ff];
      if (fwd_valid_ff && fwd_addr_ff == s1_addr) begin
         old_entry = fwd_entry_ff;
      end else if (in_range && written_ff[s1_addr]) begin
         old_entry = chan_entry_type'(ram_rd_data);
      end else begin
         old_entry = '0;
      end
      diff          = s1_time_ff - old_entry.rise_time;
      edge_seen     = enabled && (s1_level_ff != old_entry.level);
      done          = edge_seen && !s1_level_ff;
      valid         = done && (diff > {16'b0, min_ff}) && (diff < {16'b0, max_ff});
      new_entry     = old_entry;
      valid_seen_in = valid_seen_ff;
      last_valid_in = last_valid_ff;
      if (edge_seen) begin
         new_entry.level = s1_level_ff;
         if (s1_level_ff) begin
            new_entry.rise_time = s1_time_ff;
         end else begin
            new_entry.width = diff;
         end
      end
      if (valid) begin
         valid_seen_in = 1'b1;
         last_valid_in = s1_time_ff;
      end
      gap     = s1_time_ff - last_valid_in;
      present = valid_seen_in && (gap <= {8'b0, timeout_ff});
      wr_en   = s1_valid_ff && in_range;
      s1_item.result_channel = s1_ch_ff;
      s1_item.width_us       = in_range ? new_entry.width : '0;
      s1_item.width_done     = done;
      s1_item.width_valid    = valid;
      s1_item.signal_present = present;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_seen_ff <= 1'b0;
         last_valid_ff <= '0;
      end else if (s1_valid_ff) begin
         valid_seen_ff <= valid_seen_in;
         last_valid_ff <= last_valid_in;
      end
   end

   // result queue
   rsp_item_type queue_ff [QUEUE_DEPTH];
   logic [1:0]   wr_ptr_ff;
   logic [1:0]   rd_ptr_ff;
   logic [2:0]   count_ff;
   logic [2:0]   count_in;
   logic         push;
   logic         pop;
   rsp_item_type head;

   assign push = s1_valid_ff;
   assign pop  = rsp_chan.valid && rsp_chan.ready;
   assign head = queue_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 3'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == QUEUE_LAST) ? 2'd0 : wr_ptr_ff + 2'd1;
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == QUEUE_LAST) ? 2'd0 : rd_ptr_ff + 2'd1;
         end
      end
      if (push) begin
         queue_ff[wr_ptr_ff] <= s1_item;
      end
   end

   assign req_chan.ready = (count_ff + {2'b00, s1_valid_ff}) < QUEUE_FULL;

   assign rsp_chan.valid          = count_ff != 3'd0;
   assign rsp_chan.result_channel = head.result_channel;
   assign rsp_chan.width_us       = head.width_us;
   assign rsp_chan.width_done     = head.width_done;
   assign rsp_chan.width_valid    = head.width_valid;
   assign rsp_chan.signal_present = head.signal_present;

endmodule

// ----- hdl/mpwc_ram.sv -----
module mpwc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- test/multichannel_pulse_width_capture_tb.sv -----
module multichannel_pulse_width_capture_tb
   import mpwc_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int          PERIOD     = 12;
   localparam int          CHANNELS   = 16;
   localparam int          IDLE_LIMIT = 4000;
   localparam int          HOLD_AT    = 500;
   localparam int          HOLD_LEN   = 200;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_IDX = 8'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_TOP_IDX   = 8'hFF;

   typedef struct {
      logic [CHANNEL_W-1:0] channel;
      logic                 level;
      logic [TIME_W-1:0]    stamp;
   } sample_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   mpwc_req_if req_bus ();
   mpwc_rsp_if rsp_bus ();
   mpwc_csr_if csr_bus ();

   multichannel_pulse_width_capture #(.NUM_CHANNELS(CHANNELS)) u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus),
      .csr_chan (csr_bus)
   );

   always #(PERIOD / 2) clock = ~clock;

   // capture state mirror
   logic [MASK_W-1:0]    cfg_mask;
   logic [LIMIT_W-1:0]   cfg_min;
   logic [LIMIT_W-1:0]   cfg_max;
   logic [TIMEOUT_W-1:0] cfg_timeout;
   logic                 pin_state [CHANNELS];
   logic [TIME_W-1:0]    rise_at   [CHANNELS];
   logic [TIME_W-1:0]    held_width [CHANNELS];
   logic [TIME_W-1:0]    last_valid_at;
   logic                 valid_seen;

   // stimulus-side view of level and rise time, kept in step with the block
   logic                 gen_level [CHANNELS];
   logic [TIME_W-1:0]    gen_rise  [CHANNELS];
   logic [TIME_W-1:0]    t_now;

   sample_type   pending_samples[$];
   rsp_item_type expected_results[$];
   int           failures = 0;
   bit           no_gaps  = 1'b0;

   function automatic rsp_item_type capture_sample(input sample_type s);
      rsp_item_type r;
      logic [TIME_W-1:0] w;
      logic [TIME_W-1:0] gap;
      logic in_range;
      logic enabled;
      in_range = s.channel < CHANNELS;
      enabled  = in_range && cfg_mask[s.channel];
      r = '0;
      r.result_channel = s.channel;
      if (enabled && s.level != pin_state[s.channel]) begin
         pin_state[s.channel] = s.level;
         if (s.level) begin
            rise_at[s.channel] = s.stamp;
         end else begin
            w = s.stamp - rise_at[s.channel];
            held_width[s.channel] = w;
            r.width_done = 1'b1;
            if (w > {16'd0, cfg_min} && w < {16'd0, cfg_max}) begin
               r.width_valid = 1'b1;
               last_valid_at = s.stamp;
               valid_seen    = 1'b1;
            end
         end
      end
      if (in_range) r.width_us = held_width[s.channel];
      gap = s.stamp - last_valid_at;
      r.signal_present = valid_seen && (gap <= {8'd0, cfg_timeout});
      return r;
   endfunction

   // driver
   always @(posedge clock) begin
      sample_type nxt;
      sample_type got;
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            got.channel = req_bus.channel;
            got.level   = req_bus.pin_level;
            got.stamp   = req_bus.time_us;
            expected_results.push_back(capture_sample(got));
         end
         if (!req_bus.valid || req_bus.ready) begin
            if (pending_samples.size() != 0 && (no_gaps || $urandom_range(99) >= 34)) begin
               nxt = pending_samples.pop_front();
               req_bus.valid     <= 1'b1;
               req_bus.channel   <= nxt.channel;
               req_bus.pin_level <= nxt.level;
               req_bus.time_us   <= nxt.stamp;
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // monitor
   int results_seen = 0;
   int hold_left    = 0;

   always @(posedge clock) begin
      rsp_item_type want;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            results_seen++;
            if (results_seen == HOLD_AT) hold_left = HOLD_LEN;
            if (expected_results.size() == 0) begin
               failures++;
               $display("%0t: unexpected transaction, channel %0d", $time,
                        rsp_bus.result_channel);
            end else begin
               want = expected_results.pop_front();
               if (rsp_bus.result_channel !== want.result_channel ||
                   rsp_bus.width_us !== want.width_us ||
                   rsp_bus.width_done !== want.width_done ||
                   rsp_bus.width_valid !== want.width_valid ||
                   rsp_bus.signal_present !== want.signal_present) begin
                  failures++;
                  if (rsp_bus.result_channel !== want.result_channel)
                     $display("%0t: result_channel expected %0d actual %0d", $time,
                              want.result_channel, rsp_bus.result_channel);
                  if (rsp_bus.width_us !== want.width_us)
                     $display("%0t: width_us expected %0d actual %0d", $time,
                              want.width_us, rsp_bus.width_us);
                  if (rsp_bus.width_done !== want.width_done)
                     $display("%0t: width_done expected %0b actual %0b", $time,
                              want.width_done, rsp_bus.width_done);
                  if (rsp_bus.width_valid !== want.width_valid)
                     $display("%0t: width_valid expected %0b actual %0b", $time,
                              want.width_valid, rsp_bus.width_valid);
                  if (rsp_bus.signal_present !== want.signal_present)
                     $display("%0t: signal_present expected %0b actual %0b", $time,
                              want.signal_present, rsp_bus.signal_present);
               end
            end
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= no_gaps || ($urandom_range(99) >= 34);
         end
      end
   end

   // watchdog on cycles without any transaction
   int quiet_cycles = 0;

   always @(posedge clock) begin
      if (!reset) begin
         if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
             (csr_bus.valid && csr_bus.ready)) begin
            quiet_cycles <= 0;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
         if (quiet_cycles >= IDLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
         end
      end
   end

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] val);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data  <= val;
      do @(posedge clock); while (!csr_bus.ready);
      case (idx)
         CSR_ENABLE_MASK: cfg_mask    = val[MASK_W-1:0];
         CSR_MIN_WIDTH:   cfg_min     = val[LIMIT_W-1:0];
         CSR_MAX_WIDTH:   cfg_max     = val[LIMIT_W-1:0];
         CSR_TIMEOUT:     cfg_timeout = val[TIMEOUT_W-1:0];
         default: ;
      endcase
      csr_bus.valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic configure(input logic [31:0] mask, input logic [31:0] lo,
                            input logic [31:0] hi, input logic [31:0] tmo);
      write_reg(CSR_ENABLE_MASK, mask);
      write_reg(CSR_MIN_WIDTH, lo);
      write_reg(CSR_MAX_WIDTH, hi);
      write_reg(CSR_TIMEOUT, tmo);
   endtask

   task automatic send_sample(input logic [3:0] ch, input logic lvl,
                              input logic [31:0] stamp);
      sample_type s;
      s.channel = ch;
      s.level   = lvl;
      s.stamp   = stamp;
      if (cfg_mask[ch] && lvl != gen_level[ch]) begin
         gen_level[ch] = lvl;
         if (lvl) gen_rise[ch] = stamp;
      end
      pending_samples.push_back(s);
   endtask

   task automatic wait_idle();
      do @(posedge clock);
      while (pending_samples.size() != 0 || req_bus.valid || expected_results.size() != 0);
      repeat (6) @(posedge clock);
   endtask

   // widths aimed at the window edges most of the time
   function automatic logic [31:0] pick_width();
      logic [31:0] lo;
      logic [31:0] hi;
      lo = {16'd0, cfg_min};
      hi = {16'd0, cfg_max};
      case ($urandom_range(7))
         0: return lo - 1;
         1: return lo;
         2: return lo + 1;
         3: return hi - 1;
         4: return hi;
         5: return hi + 1;
         6: return (hi > lo) ? lo + $urandom_range(hi - lo) : $urandom_range(3000);
         default: return $urandom_range(70000);
      endcase
   endfunction

   task automatic random_samples(input int count);
      int r;
      logic [3:0] ch;
      logic lvl;
      logic [31:0] stamp;
      repeat (count) begin
         r = $urandom_range(99);
         do ch = 4'($urandom_range(CHANNELS - 1));
         while (cfg_mask != 0 && !cfg_mask[ch] && $urandom_range(9) != 0);
         if (r < 78) begin
            lvl = !gen_level[ch];
            stamp = lvl ? t_now : gen_rise[ch] + pick_width();
         end else if (r < 90) begin
            lvl = gen_level[ch];
            stamp = t_now;
         end else begin
            ch = 4'($urandom_range(CHANNELS - 1));
            lvl = 1'($urandom_range(1));
            stamp = $urandom();
         end
         send_sample(ch, lvl, stamp);
         t_now += $urandom_range(1, 400);
         if ($urandom_range(49) == 0) t_now += $urandom_range(100000, 400000);
      end
   endtask

   initial begin
      req_bus.valid     = 1'b0;
      req_bus.channel   = '0;
      req_bus.pin_level = 1'b0;
      req_bus.time_us   = '0;
      rsp_bus.ready     = 1'b0;
      csr_bus.valid     = 1'b0;
      csr_bus.index     = '0;
      csr_bus.data      = '0;
      cfg_mask      = RESET_ENABLE_MASK;
      cfg_min       = RESET_MIN_WIDTH;
      cfg_max       = RESET_MAX_WIDTH;
      cfg_timeout   = RESET_TIMEOUT;
      last_valid_at = '0;
      valid_seen    = 1'b0;
      for (int c = 0; c < CHANNELS; c++) begin
         pin_state[c]  = 1'b0;
         rise_at[c]    = '0;
         held_width[c] = '0;
         gen_level[c]  = 1'b0;
         gen_rise[c]   = '0;
      end
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // all channels disabled out of reset
      send_sample(4'd0, 1'b1, 32'd5);
      send_sample(4'd15, 1'b0, 32'hFFFF_FFFF);
      send_sample(4'd7, 1'b1, 32'd123);
      wait_idle();

      // default window, every channel enabled; unknown indexes are ignored
      write_reg(CSR_SPARE_IDX, 32'hFFFF_FFFF);
      write_reg(CSR_TOP_IDX, 32'd0);
      write_reg(CSR_ENABLE_MASK, 32'h0000_FFFF);
      send_sample(4'd0, 1'b1, 32'd1000);
      send_sample(4'd0, 1'b1, 32'd1100);
      send_sample(4'd0, 1'b0, 32'd1501);
      send_sample(4'd0, 1'b0, 32'd1600);
      send_sample(4'd1, 1'b1, 32'd2000);
      send_sample(4'd1, 1'b0, 32'd2500);
      send_sample(4'd2, 1'b1, 32'd3000);
      send_sample(4'd2, 1'b0, 32'd5499);
      send_sample(4'd3, 1'b1, 32'd6000);
      send_sample(4'd3, 1'b0, 32'd8500);
      send_sample(4'd4, 1'b1, 32'd0);
      send_sample(4'd4, 1'b0, 32'hFFFF_FFFF);
      send_sample(4'd15, 1'b1, 32'hFFFF_FF00);
      send_sample(4'd15, 1'b0, 32'h0000_0100);
      send_sample(4'd14, 1'b0, 32'h0000_0100 + 32'd200000);
      send_sample(4'd14, 1'b0, 32'h0000_0100 + 32'd200001);
      wait_idle();

      // channel 15 turned off keeps its stored width
      write_reg(CSR_ENABLE_MASK, 32'h0000_7FFF);
      send_sample(4'd15, 1'b1, 32'h0000_0200);
      send_sample(4'd15, 1'b0, 32'h0000_0300);
      send_sample(4'd14, 1'b1, 32'h0000_0400);
      wait_idle();

      configure(32'h0000_FFFF, 32'd500, 32'd2500, 32'd200000);
      t_now = 32'd10_000;
      random_samples(400);
      wait_idle();

      no_gaps = 1'b1;
      t_now = 32'hFFFF_0000;
      random_samples(250);
      wait_idle();
      no_gaps = 1'b0;

      configure(32'h0000_A5C3, 32'd0, 32'd65535, 32'hFF_FFFF);
      t_now = $urandom();
      random_samples(300);
      wait_idle();

      configure($urandom_range(1, 65535), 32'd65535, 32'd0, 32'd0);
      random_samples(200);
      wait_idle();

      configure(32'h0000_FFFF, 32'd1000, 32'd1000, 32'd5000);
      random_samples(200);
      wait_idle();

      configure(32'h0000_FFFF, 32'd100, 32'd3000, 32'd3000);
      random_samples(300);
      wait_idle();

      write_reg(CSR_ENABLE_MASK, 32'd0);
      random_samples(30);
      wait_idle();

      if (failures == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

// ----- files.f -----
hdl/mpwc_pkg.sv
hdl/mpwc_ifs.sv
hdl/mpwc_ram.sv
hdl/multichannel_pulse_width_capture.sv
test/multichannel_pulse_width_capture_tb.sv
